// File: hdl/maxpool_pkg.sv
package maxpool_pkg;

   // defaults for the top-level parameters
   localparam int MAX_COLS_DEFAULT   = 1024;
   localparam int PIXEL_BITS_DEFAULT = 16;

   // frame height limit is fixed
   localparam int MAX_ROWS = 1024;
   localparam int ROW_BITS = 10;
   localparam int DIM_BITS = 11;

   // stride register
   localparam int STRIDE_BITS = 4;
   localparam int STRIDE_MAX  = 15;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STRIDE     = 2'd0,
      CSR_IMAGE_COLS = 2'd1,
      CSR_IMAGE_ROWS = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 4'd2;
   localparam logic [DIM_BITS-1:0]    ROWS_RESET   = 11'd1024;

endpackage

// File: hdl/maxpool_ram.sv
module maxpool_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-first: a read and write of the same entry return the old word
   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff <= mem[addr];
         if (we) begin
            mem[addr] <= wdata;
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/max_pool_2x2_strided_unit.sv
// 2x2 max pooling over a raster stream of signed pixels.
//
// Channels: pixels enter on req_ (valid/ready), one beat per pixel in raster
// order. Pooled windows leave on rsp_ (valid/ready) with row_end and frame_end
// flags. The csr_ port writes stride (index 0), image_cols (1) and image_rows
// (2); it is always ready and must only be used while the block is idle.
//
// A window result goes through the compare stage and the output register once
// its bottom-right pixel beat is taken. Throughput: one pixel per cycle unless
// the output stalls. The line store, one single-port RAM, does a read-first
// read and write of the current column in the same cycle a pixel is taken.
//
// Reset: counters go to the top-left corner, stride 2, 1024 x 1024 (columns
// capped at MAX_COLS). The line store is not cleared; the first row fills it
// before any window reads it.
//
// Stall: a result waits in the output register while rsp_ready is low; one
// more pixel can be held in the compare stage, after which req_ready drops.
module max_pool_2x2_strided_unit #(
   parameter int MAX_COLS   = maxpool_pkg::MAX_COLS_DEFAULT,
   parameter int PIXEL_BITS = maxpool_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // pixel input
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [PIXEL_BITS-1:0]           req_pixel,
   // pooled output
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [PIXEL_BITS-1:0]           rsp_pooled,
   output logic                                   rsp_row_end,
   output logic                                   rsp_frame_end,
   // configuration writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [maxpool_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [maxpool_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   import maxpool_pkg::*;

   localparam int COL_BITS = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
   localparam int CNT_BITS = $clog2(MAX_COLS + 1);
   localparam int CMP_BITS = (CNT_BITS > DIM_BITS) ? CNT_BITS : DIM_BITS;
   localparam int SUM_BITS = CMP_BITS + 1;
   localparam int COLS_RESET = (MAX_COLS < 1024) ? MAX_COLS : 1024;

   // ---------------------------------------------------------------
   // configuration, stored already clamped
   // ---------------------------------------------------------------
   logic [STRIDE_BITS-1:0] stride_ff;
   logic [CNT_BITS-1:0]    cols_ff;
   logic [DIM_BITS-1:0]    rows_ff;
   logic [CMP_BITS-1:0]    csr_wide;
   logic [CMP_BITS-1:0]    cols_clamped;
   logic [DIM_BITS-1:0]    rows_clamped;
   csr_index_type          csr_sel;

   assign csr_ready = 1'b1;
   assign csr_sel   = csr_index_type'(csr_index);
   assign csr_wide  = CMP_BITS'(csr_data);

   always_comb begin
      if (csr_wide < CMP_BITS'(2)) begin
         cols_clamped = CMP_BITS'(2);
      end else if (csr_wide > CMP_BITS'(MAX_COLS)) begin
         cols_clamped = CMP_BITS'(MAX_COLS);
      end else begin
         cols_clamped = csr_wide;
      end
      if (csr_data < DIM_BITS'(2)) begin
         rows_clamped = DIM_BITS'(2);
      end else if (csr_data > DIM_BITS'(MAX_ROWS)) begin
         rows_clamped = DIM_BITS'(MAX_ROWS);
      end else begin
         rows_clamped = DIM_BITS'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= STRIDE_RESET;
         cols_ff   <= CNT_BITS'(COLS_RESET);
         rows_ff   <= ROWS_RESET;
      end else if (csr_valid) begin
         unique case (csr_sel)
            CSR_STRIDE: begin
               // zero stride acts as one
               stride_ff <= (csr_data[STRIDE_BITS-1:0] == '0) ?
                            STRIDE_BITS'(1) : csr_data[STRIDE_BITS-1:0];
            end
            CSR_IMAGE_COLS: cols_ff <= CNT_BITS'(cols_clamped);
            CSR_IMAGE_ROWS: rows_ff <= rows_clamped;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // position counters and stride phases
   // ---------------------------------------------------------------
   logic                req_take;
   logic [COL_BITS-1:0] col_ff;
   logic [COL_BITS-1:0] col_in;
   logic [ROW_BITS-1:0] row_ff;
   logic [ROW_BITS-1:0] row_in;
   logic                col_wrap;
   logic                row_wrap;
   logic                col_low;   // next column is 0 or 1
   logic                row_low;   // next row is 0 or 1

   // phase k holds (position - 1) mod k for stride k; one per stride value so
   // a stride change between frames never leaves a stale remainder
   logic [STRIDE_BITS-1:0] col_ph_ff [STRIDE_MAX:1];
   logic [STRIDE_BITS-1:0] row_ph_ff [STRIDE_MAX:1];

   assign col_wrap = (SUM_BITS'(col_ff) + SUM_BITS'(1)) >= SUM_BITS'(cols_ff);
   assign row_wrap = (SUM_BITS'(row_ff) + SUM_BITS'(1)) >= SUM_BITS'(rows_ff);
   assign col_in   = col_wrap ? '0 : col_ff + COL_BITS'(1);
   assign row_in   = row_wrap ? '0 : row_ff + ROW_BITS'(1);
   assign col_low  = col_wrap || (col_ff == '0);
   assign row_low  = row_wrap || (row_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_take) begin
         col_ff <= col_in;
         if (col_wrap) begin
            row_ff <= row_in;
         end
      end
   end

   for (genvar k = 1; k <= STRIDE_MAX; k++) begin : g_phase
      always_ff @(posedge clock) begin
         if (reset) begin
            col_ph_ff[k] <= '0;
            row_ph_ff[k] <= '0;
         end else if (req_take) begin
            if (col_low || col_ph_ff[k] == STRIDE_BITS'(k - 1)) begin
               col_ph_ff[k] <= '0;
            end else begin
               col_ph_ff[k] <= col_ph_ff[k] + STRIDE_BITS'(1);
            end
            if (col_wrap) begin
               if (row_low || row_ph_ff[k] == STRIDE_BITS'(k - 1)) begin
                  row_ph_ff[k] <= '0;
               end else begin
                  row_ph_ff[k] <= row_ph_ff[k] + STRIDE_BITS'(1);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // window decode at the input beat
   // ---------------------------------------------------------------
   logic hit;
   logic row_end;
   logic frame_end;

   assign hit = (row_ff != '0) && (col_ff != '0) &&
                (col_ph_ff[stride_ff] == '0) && (row_ph_ff[stride_ff] == '0);
   assign row_end   = (SUM_BITS'(col_ff) + SUM_BITS'(stride_ff)) >= SUM_BITS'(cols_ff);
   assign frame_end = row_end &&
                      ((SUM_BITS'(row_ff) + SUM_BITS'(stride_ff)) >= SUM_BITS'(rows_ff));

   // ---------------------------------------------------------------
   // line store: read-first, so the old row comes out as the new one goes in
   // ---------------------------------------------------------------
   logic signed [PIXEL_BITS-1:0] upper;

   maxpool_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_COLS)
   ) u_line_store (
      .clock (clock),
      .en    (req_take),
      .we    (req_take),
      .addr  (col_ff),
      .wdata (req_pixel),
      .rdata (upper)
   );

   // ---------------------------------------------------------------
   // compare stage and output register
   // ---------------------------------------------------------------
   logic                         s1_valid_ff;
   logic                         s1_hit_ff;
   logic                         s1_row_end_ff;
   logic                         s1_frame_end_ff;
   logic signed [PIXEL_BITS-1:0] s1_near_max_ff;   // max of pixel and left
   logic signed [PIXEL_BITS-1:0] left_ff;
   logic signed [PIXEL_BITS-1:0] upper_left_ff;
   logic signed [PIXEL_BITS-1:0] upper_max;
   logic signed [PIXEL_BITS-1:0] window_max;
   logic                         s1_move;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [PIXEL_BITS-1:0] rsp_pooled_ff;
   logic                         rsp_row_end_ff;
   logic                         rsp_frame_end_ff;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_take  = req_valid && req_ready;

   assign upper_max  = (upper > upper_left_ff) ? upper : upper_left_ff;
   assign window_max = (upper_max > s1_near_max_ff) ? upper_max : s1_near_max_ff;

   always_comb begin
      if (s1_move) begin
         rsp_valid_in = s1_hit_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         left_ff       <= '0;
         upper_left_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            s1_valid_ff <= 1'b1;
            left_ff     <= req_pixel;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         // hold the upper pixel of the item leaving as the next upper-left
         if (s1_move) begin
            upper_left_ff <= upper;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_hit_ff       <= hit;
         s1_row_end_ff   <= row_end;
         s1_frame_end_ff <= frame_end;
         s1_near_max_ff  <= (left_ff > req_pixel) ? left_ff : req_pixel;
      end
      if (s1_move) begin
         rsp_pooled_ff    <= window_max;
         rsp_row_end_ff   <= s1_row_end_ff;
         rsp_frame_end_ff <= s1_frame_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pooled    = rsp_pooled_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

// File: verif/max_pool_2x2_strided_unit_tb.sv
module max_pool_2x2_strided_unit_tb;
   import maxpool_pkg::*;

   localparam int PIX_W    = PIXEL_BITS_DEFAULT;
   localparam int MAX_COLS = MAX_COLS_DEFAULT;

   // A window leaves through the compare stage and output register after its last pixel beat; allow some slack.
   localparam int DRAIN_CYCLES   = 4;
   // Longest quiet stretch of a correct run is a sender gap plus a receiver
   // stall plus the pipeline, well under this.
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PIXELS  = 1850;

   localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};
   localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic signed [PIX_W-1:0]           req_pixel = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [PIX_W-1:0]           rsp_pooled;
   logic                              rsp_row_end;
   logic                              rsp_frame_end;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [CSR_INDEX_BITS-1:0]         csr_index = '0;
   logic [CSR_DATA_BITS-1:0]          csr_data = '0;

   max_pool_2x2_strided_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pooled    (rsp_pooled),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Pooling predictor: mirror of the block's registers and line buffer.
   // ------------------------------------------------------------------
   typedef struct {
      logic signed [PIX_W-1:0] pooled;
      logic                    row_end;
      logic                    frame_end;
   } pooled_window_t;

   pooled_window_t pending_windows[$];

   logic signed [PIX_W-1:0] line_buf [MAX_COLS];
   logic signed [PIX_W-1:0] left_q = '0;
   logic signed [PIX_W-1:0] upper_left_q = '0;
   int unsigned             row_cnt = 0;
   int unsigned             col_cnt = 0;
   logic [STRIDE_BITS-1:0]  stride_q = STRIDE_RESET;
   logic [DIM_BITS-1:0]     cols_q = DIM_BITS'(MAX_COLS);
   logic [DIM_BITS-1:0]     rows_q = ROWS_RESET;

   int unsigned mismatch_count = 0;
   int unsigned pixels_fed = 0;
   int unsigned quiet_cycles = 0;

   // burst flags switch off idling on one side for a stretch of beats
   logic send_burst = 1'b0;
   logic take_burst = 1'b0;

   // Clamp the column register the way the block does.
   function automatic int unsigned eff_cols();
      if (cols_q < 2) return 2;
      if (cols_q > MAX_COLS) return MAX_COLS;
      return cols_q;
   endfunction

   // Advance the predictor by one pixel; queue the window max if one closes here.
   function automatic void pool_pixel(input logic signed [PIX_W-1:0] pix);
      int unsigned             st;
      int unsigned             cols;
      int unsigned             rows;
      logic signed [PIX_W-1:0] upper;
      logic signed [PIX_W-1:0] peak;
      pooled_window_t          win;
      st    = (stride_q == 0) ? 1 : stride_q;
      cols  = eff_cols();
      rows  = (rows_q < 2) ? 2 : (rows_q > MAX_ROWS) ? MAX_ROWS : rows_q;
      upper = line_buf[col_cnt];
      // the bottom-right pixel of a window sits one past a stride multiple
      if (row_cnt >= 1 && col_cnt >= 1 &&
          (row_cnt - 1) % st == 0 && (col_cnt - 1) % st == 0) begin
         peak = pix;
         if (left_q > peak) peak = left_q;
         if (upper > peak) peak = upper;
         if (upper_left_q > peak) peak = upper_left_q;
         win.pooled    = peak;
         win.row_end   = (col_cnt - 1 + st) > (cols - 2);
         win.frame_end = win.row_end && ((row_cnt - 1 + st) > (rows - 2));
         pending_windows.push_back(win);
      end
      line_buf[col_cnt] = pix;
      upper_left_q      = upper;
      left_q            = pix;
      // counters past a shrunk size wrap here as well
      if (col_cnt + 1 >= cols) begin
         col_cnt = 0;
         row_cnt = (row_cnt + 1 >= rows) ? 0 : row_cnt + 1;
      end else begin
         col_cnt++;
      end
   endfunction

   // Half full-range values, with extremes and a cluster near zero for ties.
   function automatic logic signed [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return PIX_MIN;
         1: return PIX_MAX;
         2, 3: return PIX_W'($urandom_range(0, 4)) - PIX_W'(2);
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Channel drivers.
   // ------------------------------------------------------------------

   // Send one pixel beat after a random gap, predict once it is taken.
   // Leave valid high so a back-to-back beat does not toggle it.
   task automatic feed_pixel(input logic signed [PIX_W-1:0] pix);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (!req_ready);
      pool_pixel(pix);
      pixels_fed++;
   endtask

   // Feed random pixels until the raster position is back at the top-left.
   task automatic feed_to_frame_end();
      do feed_pixel(pick_pixel()); while (row_cnt != 0 || col_cnt != 0);
   endtask

   // Drop valid, wait for every pending window, then let the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_windows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write every register index back to back; the spare index gets noise.
   task automatic set_shape(input logic [CSR_DATA_BITS-1:0] stride_w,
                            input logic [CSR_DATA_BITS-1:0] cols_w,
                            input logic [CSR_DATA_BITS-1:0] rows_w);
      csr_index_type              idx;
      logic [CSR_DATA_BITS-1:0]   data;
      idx = idx.first();
      do begin
         case (idx)
            CSR_STRIDE:     data = stride_w;
            CSR_IMAGE_COLS: data = cols_w;
            CSR_IMAGE_ROWS: data = rows_w;
            default:        data = CSR_DATA_BITS'($urandom);
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= data;
         do @(posedge clock); while (!csr_ready);
         case (idx)
            CSR_STRIDE:     stride_q = data[STRIDE_BITS-1:0];
            CSR_IMAGE_COLS: cols_q   = data;
            CSR_IMAGE_ROWS: rows_q   = data;
            default: ;
         endcase
         idx = idx.next();
      end while (idx != idx.first());
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Result side: random backpressure, compare each beat with the oldest window.
   // ------------------------------------------------------------------
   initial begin : window_checker
      int             stall;
      pooled_window_t want;
      do @(posedge clock); while (reset);
      forever begin
         stall = take_burst ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_windows.size() == 0) begin
            mismatch_count++;
            $display("%0t: window beat with none pending: pooled %0d row_end %0b frame_end %0b",
                     $time, rsp_pooled, rsp_row_end, rsp_frame_end);
         end else begin
            want = pending_windows.pop_front();
            if (rsp_pooled !== want.pooled) begin
               mismatch_count++;
               $display("%0t: pooled expected %0d actual %0d",
                        $time, want.pooled, rsp_pooled);
            end
            if (rsp_row_end !== want.row_end) begin
               mismatch_count++;
               $display("%0t: row_end expected %0b actual %0b",
                        $time, want.row_end, rsp_row_end);
            end
            if (rsp_frame_end !== want.frame_end) begin
               mismatch_count++;
               $display("%0t: frame_end expected %0b actual %0b",
                        $time, want.frame_end, rsp_frame_end);
            end
         end
      end
   end

   // Abort when no channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // Reset shape: stride 2 over full-width rows; stream two rows so the
   // line buffer is filled before any window reads it.
   task automatic test_reset_shape();
      repeat (2 * MAX_COLS) feed_pixel(pick_pixel());
   endtask

   // Oversized column count clamps to the line buffer width; rows of zero clamp
   // to two, so the row counter sitting at two wraps once this row ends.
   // Stride data carries junk above the stride bits.
   task automatic test_dimension_clamp();
      wait_idle();
      set_shape(11'h7F1, 11'h7FF, 11'd0);
      feed_to_frame_end();
   endtask

   // Stride zero acts as one; 2x2 frames give one window each.
   // Walk the single max over each corner, then all-equal windows.
   task automatic test_window_extremes();
      wait_idle();
      set_shape(11'd0, 11'd2, 11'd2);
      for (int hot = 0; hot < 4; hot++) begin
         for (int k = 0; k < 4; k++) feed_pixel(k == hot ? PIX_MAX : PIX_MIN);
      end
      repeat (4) feed_pixel(PIX_MIN);
      repeat (4) feed_pixel(PIX_MAX);
   endtask

   // A mid-range stride, the largest legal stride, and low-side clamps.
   task automatic test_stride_extremes();
      wait_idle();
      set_shape(11'd8, 11'd10, 11'd10);
      feed_to_frame_end();
      wait_idle();
      set_shape(11'd15, 11'd20, 11'd17);
      feed_to_frame_end();
      wait_idle();
      set_shape(11'd2, 11'd1, 11'd3);
      feed_to_frame_end();
      wait_idle();
      set_shape(11'd1, 11'd3, 11'd1);
      feed_to_frame_end();
   endtask

   // Oversized row count clamps to the frame height limit: two columns keep
   // the full-height frame cheap; zero columns clamp to two.
   task automatic test_row_clamp();
      wait_idle();
      set_shape(11'd8, 11'd0, 11'h7FF);
      feed_to_frame_end();
   endtask

   // Resize in the middle of a frame: shrink past both counters, then grow the
   // width back over columns that an earlier wide frame already filled.
   task automatic test_mid_frame_resize();
      wait_idle();
      set_shape(11'd1, 11'd8, 11'd8);
      repeat (29) feed_pixel(pick_pixel());
      wait_idle();
      set_shape(11'd1, 11'd4, 11'd2);
      feed_to_frame_end();
      wait_idle();
      set_shape(11'd2, 11'd4, 11'd6);
      repeat (13) feed_pixel(pick_pixel());
      wait_idle();
      set_shape(11'd2, 11'd8, 11'd6);
      feed_to_frame_end();
   endtask

   // Random shapes over whole frames. Now and then cut a frame short, drain,
   // and reshape mid-frame; never widen mid-frame, so no window reads a
   // line buffer entry that this shape has not written.
   task automatic test_random_frames();
      int unsigned              start_count;
      logic [CSR_DATA_BITS-1:0] stride_w;
      logic [CSR_DATA_BITS-1:0] cols_w;
      logic [CSR_DATA_BITS-1:0] rows_w;
      start_count = pixels_fed;
      while (pixels_fed - start_count < RANDOM_PIXELS) begin
         wait_idle();
         stride_w = {7'($urandom),
                     4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(1, 3))};
         case ($urandom_range(0, 9))
            0:       cols_w = $urandom_range(0, 1);
            1:       cols_w = $urandom_range(11, 40);
            default: cols_w = $urandom_range(2, 10);
         endcase
         case ($urandom_range(0, 9))
            0:       rows_w = $urandom_range(0, 1);
            1:       rows_w = $urandom_range(9, 16);
            default: rows_w = $urandom_range(2, 8);
         endcase
         set_shape(stride_w, cols_w, rows_w);
         send_burst = ($urandom_range(0, 3) == 0);
         take_burst = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 5) == 0) begin
               repeat ($urandom_range(1, 20)) feed_pixel(pick_pixel());
               // hold the sender until every pending window is out
               wait_idle();
               set_shape(11'($urandom_range(0, 15)),
                         11'($urandom_range(0, eff_cols())),
                         11'($urandom_range(0, 12)));
            end
            feed_to_frame_end();
         end
      end
      send_burst = 1'b0;
      take_burst = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_shape();
      test_dimension_clamp();
      test_window_extremes();
      test_stride_extremes();
      test_row_clamp();
      test_mid_frame_resize();
      test_random_frames();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
